FILE: rtl/lifo_batch_process_scheduler_top_assert.svh
// assertion macros shared by the scheduler checkers
`ifndef LIFO_BATCH_PROCESS_SCHEDULER_TOP_ASSERT_SVH
`define LIFO_BATCH_PROCESS_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define LBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: rtl/lbps_pkg.sv
// shared types and sizes for the lifo batch scheduler
package lbps_pkg;

    localparam int JOB_DEPTH = 16;
    localparam int CNT_W     = $clog2(JOB_DEPTH + 1);
    localparam int ID_W      = 16;
    localparam int TIME_W    = 16;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] service;
    } t_entry;

    // one entry of each bank, indexed by bank number
    typedef t_entry [1:0] t_pair;

    typedef struct packed {
        logic push;
        logic pop;
        logic bank;
    } t_cell_ctrl;

endpackage

FILE: rtl/lbps_cell.sv
// one slot of both job banks, shifting towards or away from the top
module lbps_cell import lbps_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_pair      i_prev,
    input  t_pair      i_next,
    output t_pair      o_pair
);

    t_pair r_pair;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_pair[i_ctrl.bank] <= i_prev[i_ctrl.bank];
        end else if (i_ctrl.pop) begin
            r_pair[i_ctrl.bank] <= i_next[i_ctrl.bank];
        end
    end

    assign o_pair = r_pair;

endmodule

FILE: rtl/lifo_batch_process_scheduler_top.sv
// top level of the non-preemptive lifo batch job scheduler
// usage:
//   a word is taken at a rising edge with start high and busy low.
//   i_req_type low brings an arrival (i_job_id, i_service_time), high is one
//   time tick. every word gives exactly one result word, shown for a single
//   cycle with o_strobe high, in the cycle after the word was taken.
//   arrivals go to the pending bank; zero service or a full bank raises
//   o_arrival_dropped. a tick with no running job and an empty stack swaps
//   the banks so the newest arrival is on top, pops it and serves it.
//   o_served, o_served_id, o_remaining_before and o_job_finished describe
//   the tick; an idle tick gives all zeros.
// rate: one word every cycle once busy is low; arrivals and pops shift one
//   bank through every cell of the chain, and only the top cell is read.
// reset: synchronous, active low; banks empty, no job running, busy high
//   for the reset cycles only. bank contents are not cleared, the counts
//   keep stale cells from ever being read.
// the receiver cannot stall, so results are never held back.
module lifo_batch_process_scheduler_top import lbps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_req_type,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [TIME_W-1:0] i_service_time,
    output logic              busy,
    output logic              o_strobe,
    output logic              o_served,
    output logic [ID_W-1:0]   o_served_id,
    output logic [TIME_W-1:0] o_remaining_before,
    output logic              o_job_finished,
    output logic              o_arrival_dropped
);

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // scheduler state
    logic              r_sel, n_sel;
    logic [CNT_W-1:0]  r_stack_cnt, n_stack_cnt;
    logic [CNT_W-1:0]  r_pend_cnt, n_pend_cnt;
    logic              r_run_valid, n_run_valid;
    logic [ID_W-1:0]   r_run_id, n_run_id;
    logic [TIME_W-1:0] r_run_left, n_run_left;
    logic              r_busy;

    // result word
    logic              r_strobe;
    logic              r_served, n_served;
    logic [ID_W-1:0]   r_served_id, n_served_id;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic              r_finished, n_finished;
    logic              r_dropped, n_dropped;

    logic       w_accept;
    t_cell_ctrl w_ctrl;
    t_entry     w_new;
    t_pair      w_cell [JOB_DEPTH];
    t_pair      w_top;

    assign w_accept    = start && !r_busy;
    assign w_new.id      = i_job_id;
    assign w_new.service = i_service_time;
    assign w_top       = w_cell[0];

    // chain of slots: a push shifts the pending bank away from cell 0,
    // a pop shifts the stack bank towards cell 0, so cell 0 is always the top
    for (genvar g = 0; g < JOB_DEPTH; g++) begin : g_cell
        t_pair w_prev;
        t_pair w_next;

        if (g == 0) begin : g_head
            assign w_prev = {w_new, w_new};
        end else begin : g_body
            assign w_prev = w_cell[g-1];
        end

        if (g == JOB_DEPTH - 1) begin : g_tail
            assign w_next = w_cell[g];
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end

        lbps_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_pair (w_cell[g])
        );
    end

    always_comb begin
        n_sel       = r_sel;
        n_stack_cnt = r_stack_cnt;
        n_pend_cnt  = r_pend_cnt;
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_run_left  = r_run_left;
        n_served    = 1'b0;
        n_served_id = '0;
        n_rem       = '0;
        n_finished  = 1'b0;
        n_dropped   = 1'b0;
        w_ctrl.push = 1'b0;
        w_ctrl.pop  = 1'b0;
        w_ctrl.bank = ~r_sel;

        if (w_accept) begin
            unique case (i_req_type)
                REQ_ARRIVAL: begin
                    // zero service or full pending bank: reject
                    if (i_service_time == '0 || r_pend_cnt >= CNT_W'(JOB_DEPTH)) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_ctrl.push = 1'b1;
                        w_ctrl.bank = ~r_sel;
                        n_pend_cnt  = r_pend_cnt + 1'b1;
                    end
                end
                REQ_TICK: begin
                    if (!r_run_valid) begin
                        // stack drained: pending bank becomes the stack
                        if (r_stack_cnt == '0 && r_pend_cnt != '0) begin
                            n_sel       = ~r_sel;
                            n_stack_cnt = r_pend_cnt;
                            n_pend_cnt  = '0;
                        end
                        if (n_stack_cnt != '0) begin
                            n_stack_cnt = n_stack_cnt - 1'b1;
                            w_ctrl.pop  = 1'b1;
                            w_ctrl.bank = n_sel;
                            n_run_id    = w_top[n_sel].id;
                            n_run_left  = w_top[n_sel].service;
                            n_run_valid = (w_top[n_sel].service != '0);
                        end
                    end
                    if (n_run_valid) begin
                        n_served    = 1'b1;
                        n_served_id = n_run_id;
                        n_rem       = n_run_left;
                        n_run_left  = n_run_left - 1'b1;
                        if (n_run_left == '0) begin
                            n_finished  = 1'b1;
                            n_run_valid = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_stack_cnt <= '0;
            r_pend_cnt  <= '0;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_left  <= '0;
            r_busy      <= 1'b1;
            r_strobe    <= 1'b0;
        end else begin
            r_sel       <= n_sel;
            r_stack_cnt <= n_stack_cnt;
            r_pend_cnt  <= n_pend_cnt;
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_run_left  <= n_run_left;
            r_busy      <= 1'b0;
            r_strobe    <= w_accept;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_served    <= n_served;
        r_served_id <= n_served_id;
        r_rem       <= n_rem;
        r_finished  <= n_finished;
        r_dropped   <= n_dropped;
    end

    assign busy               = r_busy;
    assign o_strobe           = r_strobe;
    assign o_served           = r_served;
    assign o_served_id        = r_served_id;
    assign o_remaining_before = r_rem;
    assign o_job_finished     = r_finished;
    assign o_arrival_dropped  = r_dropped;

endmodule

FILE: rtl/lbps_checker.sv
// port-level checks for the scheduler, bound to the top level
`include "lifo_batch_process_scheduler_top_assert.svh"

module lbps_checker import lbps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input logic              o_served,
    input logic [TIME_W-1:0] o_remaining_before,
    input logic              o_job_finished,
    input logic              o_arrival_dropped
);

    `LBPS_ASSERT_NEXT(a_one_result_per_word, start && !busy, o_strobe)
    `LBPS_ASSERT_NEXT(a_no_result_unasked, !(start && !busy), !o_strobe)
    `LBPS_ASSERT_NOW(a_tick_never_drops, o_strobe && o_served, !o_arrival_dropped)
    `LBPS_ASSERT_NOW(a_finish_on_last_unit, o_strobe && o_job_finished,
        o_served && o_remaining_before == TIME_W'(1))

endmodule

bind lifo_batch_process_scheduler_top lbps_checker u_lbps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_strobe           (o_strobe),
    .o_served           (o_served),
    .o_remaining_before (o_remaining_before),
    .o_job_finished     (o_job_finished),
    .o_arrival_dropped  (o_arrival_dropped)
);

FILE: tb/sv/lbps_tb_pkg.sv
// word kinds shared by the scheduler testbench files
`timescale 1ns / 1ps
package lbps_tb_pkg;

    typedef enum logic {
        REQ_ARRIVAL = 1'b0,
        REQ_TICK    = 1'b1
    } t_req_kind;

endpackage

FILE: tb/sv/lbps_checker.sv
// checker for the lifo batch scheduler: tracks the job banks and compares each result word
`timescale 1ns / 1ps
module lbps_tb_checker
    import lbps_pkg::*;
    import lbps_tb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              i_req_type,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [TIME_W-1:0] i_service_time,
    input  logic              o_strobe,
    input  logic              o_served,
    input  logic [ID_W-1:0]   o_served_id,
    input  logic [TIME_W-1:0] o_remaining_before,
    input  logic              o_job_finished,
    input  logic              o_arrival_dropped,
    output int                o_fail_count,
    output int                o_outstanding,
    output int                o_words_taken,
    output int                o_ticks_served,
    output int                o_jobs_finished,
    output int                o_arrivals_dropped
);

    localparam int SLOT_W = $clog2(JOB_DEPTH);

    typedef struct packed {
        logic              served;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] left;
        logic              finished;
        logic              dropped;
    } t_report;

    // own copy of the scheduler state
    t_entry              job_store [2][JOB_DEPTH];
    logic                stack_sel;
    logic [CNT_W-1:0]    stack_n;
    logic [CNT_W-1:0]    pend_n;
    logic                run_on;
    logic [ID_W-1:0]     run_id;
    logic [TIME_W-1:0]   run_left;

    t_report             due_reports [$];
    int                  fails = 0;
    int                  words = 0;
    int                  served_n = 0;
    int                  finished_n = 0;
    int                  dropped_n = 0;

    task automatic clear_scheduler();
        stack_sel = 1'b0;
        stack_n   = '0;
        pend_n    = '0;
        run_on    = 1'b0;
        run_id    = '0;
        run_left  = '0;
    endtask

    // one arrival or one tick applied to the tracked state
    task automatic schedule_word(input logic req, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] st, output t_report rep);
        t_entry e;
        rep = '0;
        if (req == REQ_ARRIVAL) begin
            if (st == '0 || pend_n >= JOB_DEPTH) begin
                rep.dropped = 1'b1;
            end else begin
                e.id      = id;
                e.service = st;
                job_store[~stack_sel][pend_n[SLOT_W-1:0]] = e;
                pend_n = pend_n + 1'b1;
            end
        end else begin
            if (!run_on) begin
                // stack drained: pending bank takes over, newest on top
                if (stack_n == '0 && pend_n != '0) begin
                    stack_sel = ~stack_sel;
                    stack_n   = pend_n;
                    pend_n    = '0;
                end
                if (stack_n != '0) begin
                    stack_n  = stack_n - 1'b1;
                    e        = job_store[stack_sel][stack_n[SLOT_W-1:0]];
                    run_id   = e.id;
                    run_left = e.service;
                    run_on   = (run_left != '0);
                end
            end
            if (run_on) begin
                rep.served = 1'b1;
                rep.id     = run_id;
                rep.left   = run_left;
                run_left   = run_left - 1'b1;
                if (run_left == '0) begin
                    rep.finished = 1'b1;
                    run_on       = 1'b0;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            clear_scheduler();
            due_reports.delete();
        end else begin
            // result of the previous word is checked before this edge's word is added
            if (o_strobe) begin
                if (due_reports.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fails++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("served", want.served, o_served);
                    check_field("served_id", want.id, o_served_id);
                    check_field("remaining_before", want.left, o_remaining_before);
                    check_field("job_finished", want.finished, o_job_finished);
                    check_field("arrival_dropped", want.dropped, o_arrival_dropped);
                end
            end
            if (start && !busy) begin
                schedule_word(i_req_type, i_job_id, i_service_time, want);
                due_reports.push_back(want);
                words++;
                if (want.served)   served_n++;
                if (want.finished) finished_n++;
                if (want.dropped)  dropped_n++;
            end
        end
        o_fail_count       <= fails;
        o_outstanding      <= due_reports.size();
        o_words_taken      <= words;
        o_ticks_served     <= served_n;
        o_jobs_finished    <= finished_n;
        o_arrivals_dropped <= dropped_n;
    end

endmodule

FILE: tb/sv/tb_lifo_batch_process_scheduler_top.sv
// testbench top for the lifo batch scheduler: stimulus, run limit and verdict
`timescale 1ns / 1ps
module tb_lifo_batch_process_scheduler_top;
    import lbps_pkg::*;
    import lbps_tb_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int RAND_WORDS  = 1200;
    localparam int IDLE_PCT    = 24;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              i_req_type;
    logic [ID_W-1:0]   i_job_id;
    logic [TIME_W-1:0] i_service_time;
    logic              busy;
    logic              o_strobe;
    logic              o_served;
    logic [ID_W-1:0]   o_served_id;
    logic [TIME_W-1:0] o_remaining_before;
    logic              o_job_finished;
    logic              o_arrival_dropped;

    int                fail_count;
    int                outstanding;
    int                words_taken;
    int                ticks_served;
    int                jobs_finished;
    int                arrivals_dropped;
    int                cycle_cnt = 0;
    bit                idle_on = 1'b1;

    lifo_batch_process_scheduler_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_req_type         (i_req_type),
        .i_job_id           (i_job_id),
        .i_service_time     (i_service_time),
        .busy               (busy),
        .o_strobe           (o_strobe),
        .o_served           (o_served),
        .o_served_id        (o_served_id),
        .o_remaining_before (o_remaining_before),
        .o_job_finished     (o_job_finished),
        .o_arrival_dropped  (o_arrival_dropped)
    );

    lbps_tb_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_job_id           (i_job_id),
        .i_service_time     (i_service_time),
        .o_strobe           (o_strobe),
        .o_served           (o_served),
        .o_served_id        (o_served_id),
        .o_remaining_before (o_remaining_before),
        .o_job_finished     (o_job_finished),
        .o_arrival_dropped  (o_arrival_dropped),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding),
        .o_words_taken      (words_taken),
        .o_ticks_served     (ticks_served),
        .o_jobs_finished    (jobs_finished),
        .o_arrivals_dropped (arrivals_dropped)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one word and return at the edge that takes it
    // busy is looked at on the falling edge, where it is settled
    task automatic send_word(input t_req_kind req, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] st);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_job_id       <= id;
        i_service_time <= st;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // tick fields are ignored, so they carry random bits
    task automatic send_tick();
        send_word(REQ_TICK, ID_W'($urandom), TIME_W'($urandom));
    endtask

    // sender goes quiet until every result word is back
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // mostly short jobs so the stack keeps turning over
    function automatic logic [TIME_W-1:0] pick_service();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return '0;
        if (r < 88) return TIME_W'($urandom_range(1, 6));
        return TIME_W'($urandom_range(7, 40));
    endfunction

    initial begin
        int n_rand;
        int pick;
        int k;
        int next_drain;

        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_req_type     <= REQ_ARRIVAL;
        i_job_id       <= '0;
        i_service_time <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, zero service drop, lifo order, arrival
        // while the stack holds a job, swap of banks, then a full pending bank
        send_tick();
        send_word(REQ_ARRIVAL, 16'hFFFF, 16'h0000);
        send_word(REQ_ARRIVAL, 16'h0000, 16'h0002);
        send_word(REQ_ARRIVAL, 16'hFFFF, 16'h0001);
        send_tick();
        send_word(REQ_ARRIVAL, 16'h0055, 16'h0001);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        for (k = 0; k < JOB_DEPTH; k++)
            send_word(REQ_ARRIVAL, ID_W'(16'h1000 + k), 16'h0001);
        send_word(REQ_ARRIVAL, 16'hFFFF, 16'hFFFF);

        // long job: remaining count walks down over a few hundred ticks
        for (k = 0; k < 20; k++)
            send_tick();
        send_word(REQ_ARRIVAL, 16'hA5A5, 16'h0100);
        for (k = 0; k <= 32'h0100; k++)
            send_tick();
        hold_until_drained();

        // random: mostly bursts of arrivals then ticks, some noise and overflow
        n_rand     = 0;
        next_drain = 350;
        while (n_rand < RAND_WORDS) begin
            idle_on = !(n_rand >= 600 && n_rand < 900);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // noise: any kind, random content
                if ($urandom_range(0, 1))
                    send_tick();
                else
                    send_word(REQ_ARRIVAL, ID_W'($urandom), TIME_W'($urandom_range(0, 7)));
                n_rand++;
            end else if (pick < 22) begin
                // overflow: sixteen live arrivals leave the bank full,
                // so the wide service values after them are dropped
                for (k = 0; k < JOB_DEPTH; k++)
                    send_word(REQ_ARRIVAL, ID_W'($urandom), TIME_W'($urandom_range(1, 4)));
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_word(REQ_ARRIVAL, ID_W'($urandom), TIME_W'($urandom));
                n_rand += JOB_DEPTH;
            end else begin
                for (k = $urandom_range(1, 8); k > 0; k--) begin
                    send_word(REQ_ARRIVAL, ID_W'($urandom), pick_service());
                    n_rand++;
                end
                for (k = $urandom_range(1, 30); k > 0; k--) begin
                    send_tick();
                    n_rand++;
                end
            end
            if (n_rand >= next_drain) begin
                hold_until_drained();
                next_drain += 350;
            end
        end

        // drain, then allow a margin after the registered results
        idle_on = 1'b1;
        hold_until_drained();
        repeat (4) @(posedge i_clk);

        $display("run covered %0d words: %0d ticks served a job, %0d jobs finished",
                 words_taken, ticks_served, jobs_finished);
        $display("%0d arrivals dropped (zero service or full bank), %0d cycles",
                 arrivals_dropped, cycle_cnt);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lbps_pkg.sv
rtl/lbps_cell.sv
rtl/lifo_batch_process_scheduler_top.sv
rtl/lbps_checker.sv
tb/sv/lbps_tb_pkg.sv
tb/sv/lbps_checker.sv
tb/sv/tb_lifo_batch_process_scheduler_top.sv
